[rtl/llf_pkg.sv]
// ----------------------------------------------------------------------------
// llf_pkg
// shared types, constants and the saturator table of the ladder lowpass filter
// ----------------------------------------------------------------------------
package llf_pkg;

    // internal ticks per input sample (power of two) and ladder depth
    localparam int OVERSAMPLE     = 2;
    localparam int STAGE_COUNT    = 4;
    // saturator table size, power of two
    localparam int SAT_TABLE_SIZE = 256;

    localparam int TICK_W  = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam int OS_SHIFT = $clog2(OVERSAMPLE);
    localparam int STG_W   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int SAT_IDX_W = $clog2(SAT_TABLE_SIZE);
    localparam int FRAC_W  = 29 - SAT_IDX_W;

    localparam int SAMPLE_W = 24;
    localparam int G_W      = 24;
    localparam int FB_W     = 25;
    localparam int CFG_W    = 25;
    localparam int STATE_W  = 32;
    localparam int IN27_W   = 28;
    localparam int X_W      = 38;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 26;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = STATE_W + $clog2(OVERSAMPLE) + 1;

    localparam logic [G_W-1:0]  G_RESET  = G_W'(531822);
    localparam logic [FB_W-1:0] FB_RESET = FB_W'(3355443);

    typedef enum logic [0:0] {
        REG_STAGE_COEF    = 1'b0,
        REG_FEEDBACK_GAIN = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IN_MUL,
        ST_FB_MUL,
        ST_X_FORM,
        ST_SAT_MUL,
        ST_SAT_FORM,
        ST_STG_MUL,
        ST_STG_UPD,
        ST_OUT_FORM
    } llf_state_t;

    typedef struct packed {
        logic                 neg;
        logic                 over;
        logic [23:0]          lo;
        logic [23:0]          diff;
        logic [FRAC_W-1:0]    frac;
    } sat_lookup_t;

    typedef logic [SAT_TABLE_SIZE:0][23:0] sat_rom_t;

    // unsigned long division, only for table construction at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8*i/N) in Q1.23, evaluated at elaboration
    function automatic sat_rom_t build_sat_rom();
        sat_rom_t   rom;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        rom  = '0;
        h    = (64'd8 << 32) >> SAT_IDX_W;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 12; k++)
        begin
            term = udiv64((term * h) >> 32, 64'(k));
            if ((k & 1) == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        r = acc;
        p = 64'd1 << 32;
        for (int k = 0; k <= SAT_TABLE_SIZE; k++)
        begin
            num    = (64'd1 << 32) - p;
            den    = (64'd1 << 32) + p;
            rom[k] = 24'(udiv64((num << 23) + (den >> 1), den));
            p      = (p * r + (64'd1 << 31)) >> 32;
            p      = (p * r + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam sat_rom_t SAT_ROM = build_sat_rom();

    // clip a 36-bit sum to the 32-bit state range
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [STATE_W-1:0] res;
        if (v > 36'sh0_7FFF_FFFF)
            res = 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            res = 32'sh8000_0000;
        else
            res = v[STATE_W-1:0];
        return res;
    endfunction

endpackage

[rtl/llf_mul.sv]
// ----------------------------------------------------------------------------
// llf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module llf_mul (
    input  logic                                 clk,
    input  logic signed [llf_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [llf_pkg::MUL_B_W-1:0]   op_b,
    output logic signed [llf_pkg::PROD_W-1:0]    prod
);
    import llf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[rtl/llf_sat_lut.sv]
// ----------------------------------------------------------------------------
// llf_sat_lut
// tanh table lookup: magnitude, segment endpoints and interpolation fraction
// ----------------------------------------------------------------------------
module llf_sat_lut (
    input  logic signed [llf_pkg::X_W-1:0] x,
    output llf_pkg::sat_lookup_t           lk
);
    import llf_pkg::*;

    logic [X_W-1:0]       mag;
    logic [SAT_IDX_W-1:0] idx;
    logic [SAT_IDX_W:0]   idx_hi;
    logic [23:0]          lo;
    logic [23:0]          hi;

    assign mag    = x[X_W-1] ? (~x + X_W'(1)) : x;
    assign idx    = mag[28:FRAC_W];
    assign idx_hi = {1'b0, idx} + (SAT_IDX_W+1)'(1);
    assign lo     = SAT_ROM[idx];
    assign hi     = SAT_ROM[idx_hi];

    always_comb
    begin
        lk.neg  = x[X_W-1];
        // at or beyond 4.0 the curve is flat
        lk.over = |mag[X_W-1:29];
        lk.lo   = lo;
        lk.diff = (hi >= lo) ? (hi - lo) : 24'd0;
        lk.frac = mag[FRAC_W-1:0];
    end

endmodule

[rtl/ladder_lowpass_filter.sv]
// ----------------------------------------------------------------------------
// ladder_lowpass_filter
// four-pole saturating ladder lowpass, oversampled, one shared multiplier
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)         handshake
//  s_axis    in   tdata: input_sample [23:0]     tvalid/tready
//  m_axis    out  tdata: output_sample [23:0]    tvalid/tready
//  cfg       in   addr 0 stage_coefficient,      cfg_we, no wait
//                 addr 1 feedback_gain
//
//  one request at a time runs its OVERSAMPLE ticks of STAGE_COUNT poles,
//  paced by the single registered multiplier every product goes through
//  s_axis_tready is high only in idle; a result waits in the output register
//  and the sequencer holds in its final step while that register is full
//  rst_n clears the ladder state, feedback sample, sequencer and output valid, and loads the config registers
// ----------------------------------------------------------------------------
module ladder_lowpass_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // [23:0] input_sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // [23:0] output_sample
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [llf_pkg::CFG_W-1:0]     cfg_wdata
);
    import llf_pkg::*;

    // sequencer
    llf_state_t              state_reg, state_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [STG_W-1:0]        stage_reg, stage_next;

    // configuration
    logic [G_W-1:0]          g_reg;
    logic [FB_W-1:0]         fb_reg;

    // datapath registers
    logic signed [IN27_W-1:0]   in27_reg, in27_next;
    logic signed [STATE_W-1:0]  term_reg, term_next;
    logic signed [X_W-1:0]      x_reg, x_next;
    logic                       neg_reg, neg_next;
    logic                       over_reg, over_next;
    logic [23:0]                lo_reg, lo_next;
    logic signed [STATE_W-1:0]  u_reg, u_next;
    logic signed [STATE_W-1:0]  s_reg [STAGE_COUNT];
    logic signed [STATE_W-1:0]  s_next;
    logic                       s_we;
    logic signed [STATE_W-1:0]  fbs_reg, fbs_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [23:0]                out_data_reg, out_data_next;
    logic                       out_valid_reg, out_valid_next;

    // shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    sat_lookup_t                lk;

    // combinational helpers
    logic signed [36:0]         fb_term;
    logic [MUL_B_W-1:0]         makeup;
    logic [23:0]                interp;
    logic [24:0]                y_mag;
    logic signed [STATE_W-1:0]  y_q27;
    logic signed [STATE_W-1:0]  s_cur;
    logic signed [34:0]         v;
    logic signed [STATE_W-1:0]  o;
    logic signed [ACC_W-1:0]    acc_avg;
    logic signed [ACC_W-1:0]    acc_out;
    logic                       in_acc;
    logic                       out_free;

    llf_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    llf_sat_lut u_sat_lut (
        .x  (x_reg),
        .lk (lk)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // passband makeup 1 + fb/2 in Q2.22
    assign makeup  = MUL_B_W'(25'd4194304 + {1'b0, fb_reg[FB_W-1:1]});
    // fb * feedback_sample, floor by 2^22
    assign fb_term = prod[PROD_W-1:22];
    // table interpolation step
    assign interp  = prod[FRAC_W+23:FRAC_W];
    assign y_mag   = over_reg ? {1'b0, SAT_ROM[SAT_TABLE_SIZE]} :
                                ({1'b0, lo_reg} + {1'b0, interp});
    assign y_q27   = neg_reg ? -$signed({3'b000, y_mag, 4'b0000}) :
                               $signed({3'b000, y_mag, 4'b0000});
    // one-pole stage
    assign s_cur   = s_reg[stage_reg];
    assign v       = prod[PROD_W-1:24];
    assign o       = sat32(36'(v) + 36'(s_cur));
    // average the tick outputs, truncating toward zero: bias negatives, then shift
    assign acc_avg = (acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(OVERSAMPLE - 1) : ACC_W'(0)))
                     >>> OS_SHIFT;
    assign acc_out = acc_avg >>> 4;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg  <= G_RESET;
            fb_reg <= FB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_STAGE_COEF:    g_reg  <= cfg_wdata[G_W-1:0];
                REG_FEEDBACK_GAIN: fb_reg <= cfg_wdata[FB_W-1:0];
                default:           g_reg  <= g_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            stage_reg     <= '0;
            fbs_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STAGE_COUNT; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            stage_reg     <= stage_next;
            fbs_reg       <= fbs_next;
            out_valid_reg <= out_valid_next;
            if (s_we)
            begin
                s_reg[stage_reg] <= s_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in27_reg     <= in27_next;
        term_reg     <= term_next;
        x_reg        <= x_next;
        neg_reg      <= neg_next;
        over_reg     <= over_next;
        lo_reg       <= lo_next;
        u_reg        <= u_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        stage_next     = stage_reg;
        in27_next      = in27_reg;
        term_next      = term_reg;
        x_next         = x_reg;
        neg_next       = neg_reg;
        over_next      = over_reg;
        lo_next        = lo_reg;
        u_next         = u_reg;
        s_next         = s_cur;
        s_we           = 1'b0;
        fbs_next       = fbs_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // Q1.23 to Q1.27
                    in27_next  = $signed({s_axis_tdata, 4'b0000});
                    acc_next   = '0;
                    tick_next  = '0;
                    stage_next = '0;
                    state_next = ST_IN_MUL;
                end
            end
            ST_IN_MUL:
            begin
                mul_a      = MUL_A_W'(in27_reg);
                mul_b      = $signed(makeup);
                state_next = ST_FB_MUL;
            end
            ST_FB_MUL:
            begin
                term_next  = prod[53:22];
                mul_a      = MUL_A_W'(fbs_reg);
                mul_b      = $signed({1'b0, fb_reg});
                state_next = ST_X_FORM;
            end
            ST_X_FORM:
            begin
                x_next     = X_W'(term_reg) - X_W'(fb_term);
                state_next = ST_SAT_MUL;
            end
            ST_SAT_MUL:
            begin
                neg_next   = lk.neg;
                over_next  = lk.over;
                lo_next    = lk.lo;
                mul_a      = $signed({{(MUL_A_W-24){1'b0}}, lk.diff});
                mul_b      = $signed({{(MUL_B_W-FRAC_W){1'b0}}, lk.frac});
                state_next = ST_SAT_FORM;
            end
            ST_SAT_FORM:
            begin
                u_next     = y_q27;
                state_next = ST_STG_MUL;
            end
            ST_STG_MUL:
            begin
                mul_a      = MUL_A_W'(u_reg) - MUL_A_W'(s_cur);
                mul_b      = $signed({{(MUL_B_W-G_W){1'b0}}, g_reg});
                state_next = ST_STG_UPD;
            end
            ST_STG_UPD:
            begin
                s_next = sat32(36'(o) + 36'(v));
                s_we   = 1'b1;
                u_next = o;
                if (stage_reg == STG_W'(STAGE_COUNT - 1))
                begin
                    // last pole feeds back and adds to the tick sum
                    fbs_next   = o;
                    acc_next   = acc_reg + ACC_W'(o);
                    stage_next = '0;
                    if (tick_reg == TICK_W'(OVERSAMPLE - 1))
                        state_next = ST_OUT_FORM;
                    else
                    begin
                        tick_next  = tick_reg + TICK_W'(1);
                        state_next = ST_IN_MUL;
                    end
                end
                else
                begin
                    stage_next = stage_reg + STG_W'(1);
                    state_next = ST_STG_MUL;
                end
            end
            ST_OUT_FORM:
            begin
                if (out_free)
                begin
                    if (acc_out > $signed(ACC_W'(8388607)))
                        out_data_next = 24'h7FFFFF;
                    else if (acc_out < -$signed(ACC_W'(8388608)))
                        out_data_next = 24'h800000;
                    else
                        out_data_next = acc_out[23:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // one request at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("ready stayed high after an accepted request");

    // a new result only comes from the output step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT_FORM))
        else $error("result appeared outside the output step");

    // every tick starts from the first pole
    a_tick_starts_at_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IN_MUL) |-> (stage_reg == '0))
        else $error("tick started with a nonzero stage index");

    // pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");
`endif

endmodule

[tb/llf_checker.sv]
// ----------------------------------------------------------------------------
// llf_checker
// watches the stream and config channels of the ladder lowpass filter,
// predicts every output sample and compares it with what the block sends
// ----------------------------------------------------------------------------
module llf_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [23:0]               s_axis_tdata,   // [23:0] input_sample
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [23:0]               m_axis_tdata,   // [23:0] output_sample
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [llf_pkg::CFG_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        pending,
    output int                        checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import llf_pkg::*;

    logic [23:0]      tanh_tab [0:SAT_TABLE_SIZE];
    longint           ladder [STAGE_COUNT];
    longint           fb_hist;
    logic [G_W-1:0]   coef_g;
    logic [FB_W-1:0]  gain_fb;
    logic [23:0]      expected_out [$];

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // exp(-8/N) by series, then tanh(8i/N) = (1-r^2i)/(1+r^2i)
    task automatic fill_tanh();
        longint unsigned h, term, acc, r, p, num, den;
        h    = (64'd8 << 32) / SAT_TABLE_SIZE;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * h) >> 32) / k;
            acc  = (k & 1) ? acc - term : acc + term;
        end
        r = acc;
        p = 64'd1 << 32;
        for (int k = 0; k <= SAT_TABLE_SIZE; k++)
        begin
            num         = (64'd1 << 32) - p;
            den         = (64'd1 << 32) + p;
            tanh_tab[k] = 24'(((num << 23) + den / 2) / den);
            p           = (p * r + (64'd1 << 31)) >> 32;
            p           = (p * r + (64'd1 << 31)) >> 32;
        end
    endtask

    function automatic longint soft_clip(longint x);
        longint unsigned a, pos, idx, frac, lo, hi, y;
        a = (x < 0) ? -x : x;
        if (a >= (64'd4 << 27))
            y = tanh_tab[SAT_TABLE_SIZE];
        else
        begin
            pos  = a * SAT_TABLE_SIZE;
            idx  = pos >> 29;
            frac = pos & ((64'd1 << 29) - 1);
            if (idx > SAT_TABLE_SIZE - 1)
                idx = SAT_TABLE_SIZE - 1;
            lo = tanh_tab[idx];
            hi = tanh_tab[idx + 1];
            y  = lo + ((hi >= lo) ? (((hi - lo) * frac) >> 29) : 0);
        end
        y = y << 4;
        return (x < 0) ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint ladder_tick(longint in27);
        longint makeup, x, u, s, v, o;
        makeup = (64'sd1 << 22) + longint'(gain_fb >> 1);
        x = ((in27 * makeup) >>> 22) - ((longint'(gain_fb) * fb_hist) >>> 22);
        u = soft_clip(x);
        for (int i = 0; i < STAGE_COUNT; i++)
        begin
            s         = ladder[i];
            v         = ((u - s) * longint'(coef_g)) >>> 24;
            o         = clip32(v + s);
            ladder[i] = clip32(o + v);
            u         = o;
        end
        fb_hist = u;
        return u;
    endfunction

    function automatic logic [23:0] filter_sample(logic signed [23:0] smp);
        longint sum, y;
        sum = 0;
        for (int k = 0; k < OVERSAMPLE; k++)
            sum += ladder_tick(longint'(smp) * 16);
        sum = sum / OVERSAMPLE;
        y = sum >>> 4;
        if (y > 8388607)
            y = 8388607;
        if (y < -8388608)
            y = -8388608;
        return y[23:0];
    endfunction

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        checked    = 0;
        fill_tanh();
    end

    assign pending = expected_out.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGE_COUNT; i++)
                ladder[i] = 0;
            fb_hist = 0;
            coef_g  = G_RESET;
            gain_fb = FB_RESET;
            expected_out.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("unexpected output sample %0d at %0t",
                             $signed(m_axis_tdata), $realtime);
                    fail_count++;
                end
                else
                begin
                    if (m_axis_tdata !== expected_out[0])
                        report("output_sample", m_axis_tdata, expected_out[0]);
                    void'(expected_out.pop_front());
                    checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_out.push_back(filter_sample(s_axis_tdata));
            if (cfg_we)
            begin
                if (cfg_addr == REG_STAGE_COEF)
                    coef_g = cfg_wdata[G_W-1:0];
                else
                    gain_fb = cfg_wdata[FB_W-1:0];
            end
        end
    end

    final
    begin
    end
endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// regression for the ladder lowpass filter: directed extremes, then random
// audio in phases with different coefficient settings, bursty requests and
// a stalling receiver; the checker predicts and compares every output
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import llf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // [23:0] input_sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;        // [23:0] output_sample
    logic                 cfg_we = 1'b0;
    logic                 cfg_addr = REG_STAGE_COEF;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int fail_count, pending, checked;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;
    int idle_cycles = 0;
    int requests_sent = 0;
    int phases_run = 0;

    always #6 clk = ~clk;

    ladder_lowpass_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    llf_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    // receiver back-pressure: always ready, coin flip, or long periodic stalls
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (stall_phase % 97) > 40;
        endcase
    end

    // no request moving in either direction for too long means a hang
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("ladder_lowpass_filter regression: fail");
            $finish;
        end
    end

    // one input request; bursts of random length separated by random gaps
    task automatic send_sample(logic [23:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // drain outputs, let the sequencer settle, then write both registers
    task automatic set_coefficients(logic [CFG_W-1:0] g, logic [CFG_W-1:0] fb);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_STAGE_COEF;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_addr  <= REG_FEEDBACK_GAIN;
        cfg_wdata <= fb;
        @(posedge clk);
        cfg_we    <= 1'b0;
        phases_run++;
    endtask

    // random audio: mostly full range, some quiet, some held steps
    task automatic random_audio(int count);
        logic [23:0] smp;
        int held;
        held = 0;
        for (int n = 0; n < count; n++)
        begin
            if (held > 0)
                held--;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       smp = 24'($urandom_range(0, 32'hFFFFFF));
                    1:       smp = 24'($signed($urandom_range(0, 4000)) - 2000);
                    2:       smp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                    default: smp = 24'($urandom);
                endcase
                if ($urandom_range(0, 4) == 0)
                    held = $urandom_range(2, 20);
            end
            send_sample(smp);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset coefficients, full scale steps and small values
        stall_mode = 0;
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);

        // no resonance, zero stage coefficient: the ladder state holds
        set_coefficients(25'd0, 25'd0);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        // max in-range settings: heavy feedback drives the saturator past 4.0
        set_coefficients(25'd8388608, 25'd16777216);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? 24'h800000 : 24'h7FFFFF);
        // registers above their range, unstable ladder clips at the state limit
        set_coefficients(25'hFFFFFF, 25'h1FFFFFF);
        for (int i = 0; i < 6; i++)
            send_sample(i[1] ? 24'h800000 : 24'h7FFFFF);

        // random phases with varied settings and back-pressure
        for (int ph = 0; ph < 8; ph++)
        begin
            stall_mode = ph % 3;
            case (ph)
                0:       set_coefficients(25'(G_RESET), 25'(FB_RESET));
                1:       set_coefficients(25'd8388608, 25'd16777216);
                2:       set_coefficients(25'd1, 25'd0);
                3:       set_coefficients(25'hFFFFFF, 25'h1FFFFFF);
                default: set_coefficients(25'($urandom_range(0, 8388608)),
                                          25'($urandom_range(0, 16777216)));
            endcase
            random_audio(190);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d samples over %0d coefficient settings", requests_sent,
                 phases_run + 1);
        $display("checked %0d output samples, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("ladder_lowpass_filter regression: pass");
        else
            $display("ladder_lowpass_filter regression: fail");
        $finish;
    end
endmodule
